// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define I2CM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/i2cm_seq_pkg.sv -----
// Types and constants of the I2C master transfer sequencer.
package i2cm_seq_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int RW_BIT      = 0;        // read flag in the SLA+R/W byte
    localparam logic [7:0] POS_MAX = 8'hFF;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_STATUS = 2'd3
    } req_type_t;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_REL   = 3'd1;
    localparam logic [2:0] ACT_ACK   = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_START = 3'd4;

    localparam logic [7:0] CODE_START        = 8'h08;
    localparam logic [7:0] CODE_RSTART       = 8'h10;
    localparam logic [7:0] CODE_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] CODE_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] CODE_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] CODE_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] CODE_ARB_LOST     = 8'h38;
    localparam logic [7:0] CODE_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] CODE_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] CODE_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] CODE_MR_DATA_NACK = 8'h58;

    typedef struct packed {
        req_type_t   req_type;
        logic [6:0]  slave_address;
        logic [7:0]  byte_count;
        logic [7:0]  load_index;
        logic [7:0]  load_byte;
        logic [7:0]  bus_status;
        logic [7:0]  received_byte;
    } i2cm_seq_in_t;

    typedef struct packed {
        logic [2:0]  bus_action;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_valid;
        logic [7:0]  rx_index;
        logic [7:0]  rx_byte;
        logic        busy_res;
        logic        error;
        logic        done_res;
    } i2cm_seq_out_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

endpackage

// ----- rtl/i2cm_seq_store.sv -----
// Write-data store with registered reads at the requested address and at entry zero.
module i2cm_seq_store (
    input  logic                              aclk,
    input  i2cm_seq_pkg::store_wr_t           wr,
    input  logic [i2cm_seq_pkg::STORE_AW-1:0] rd_addr,
    output logic [7:0]                        rd_pos_data,
    output logic [7:0]                        rd_zero_data
);
    import i2cm_seq_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_pos_reg;
    logic [7:0] rd_zero_reg;

    // Reads see the word written on the same edge.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_pos_reg  <= (wr.en && wr.addr == rd_addr) ? wr.data : mem[rd_addr];
        rd_zero_reg <= (wr.en && wr.addr == '0) ? wr.data : mem[0];
    end

    assign rd_pos_data  = rd_pos_reg;
    assign rd_zero_data = rd_zero_reg;

endmodule

// ----- rtl/i2c_master_transfer_sequencer.sv -----
// I2C master transfer sequencer: top level with input and result registers.
//
//  channel | ports                      | word
//  --------+----------------------------+-------------------------------
//  in      | s_valid s_ready s_data     | load / start / bus status item
//  out     | m_valid m_ready m_data     | bus action, tx/rx byte, flags
//
// One word per cycle sustained while m_ready stays high; a word passes the input register
// and then the result register. The store is read at the next position as a word fires, so a status word
// finds its data byte in a register.
// aresetn is synchronous; the store content is not cleared by it.
// A stalled result holds the input register; s_ready drops only then.
module i2c_master_transfer_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  i2cm_seq_pkg::i2cm_seq_in_t  s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output i2cm_seq_pkg::i2cm_seq_out_t m_data
);
    import i2cm_seq_pkg::*;

    logic          in_valid_reg;
    i2cm_seq_in_t  in_reg;
    logic          out_valid_reg;
    i2cm_seq_out_t out_reg;

    logic [7:0] address_byte_reg,  address_byte_next;
    logic [7:0] block_length_reg,  block_length_next;
    logic [7:0] byte_position_reg, byte_position_next;
    logic       busy_reg,          busy_next;
    logic       error_reg,         error_next;

    i2cm_seq_out_t res;
    logic          fire;
    store_wr_t     wr;
    logic [7:0]    rd_pos_data;
    logic [7:0]    rd_zero_data;
    logic [7:0]    pos_adv;
    logic          is_rd;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign is_rd   = address_byte_reg[RW_BIT];
    assign pos_adv = (byte_position_reg == POS_MAX) ? byte_position_reg
                                                    : byte_position_reg + 8'd1;

    assign wr.en   = fire && in_reg.req_type == REQ_LOAD
                     && int'(in_reg.load_index) < STORE_DEPTH;
    assign wr.addr = STORE_AW'(in_reg.load_index);
    assign wr.data = in_reg.load_byte;

    i2cm_seq_store u_store (
        .aclk         (aclk),
        .wr           (wr),
        .rd_addr      (STORE_AW'(fire ? byte_position_next : byte_position_reg)),
        .rd_pos_data  (rd_pos_data),
        .rd_zero_data (rd_zero_data)
    );

    always_comb begin
        logic done;
        done               = 1'b0;
        address_byte_next  = address_byte_reg;
        block_length_next  = block_length_reg;
        byte_position_next = byte_position_reg;
        busy_next          = busy_reg;
        error_next         = error_reg;
        res                = '0;
        res.bus_action     = ACT_NONE;

        case (in_reg.req_type)
            REQ_LOAD: begin
            end
            REQ_WRITE, REQ_READ: begin
                address_byte_next  = {in_reg.slave_address, in_reg.req_type == REQ_READ};
                block_length_next  = in_reg.byte_count;
                byte_position_next = '0;
                busy_next          = 1'b1;
                error_next         = 1'b0;
                res.bus_action     = ACT_START;
            end
            REQ_STATUS: begin
                if (busy_reg) begin
                    case (in_reg.bus_status)
                        CODE_START, CODE_RSTART: begin
                            res.tx_valid   = 1'b1;
                            res.tx_byte    = address_byte_reg;
                            res.bus_action = ACT_REL;
                        end
                        CODE_ARB_LOST: begin
                            byte_position_next = '0;
                            res.bus_action     = ACT_START;
                        end
                        CODE_MR_SLA_ACK: begin
                            if (is_rd) begin
                                res.bus_action = (block_length_reg > 8'd1) ? ACT_ACK : ACT_REL;
                            end
                        end
                        CODE_MR_SLA_NACK, CODE_MT_SLA_NACK: begin
                            if (is_rd == (in_reg.bus_status == CODE_MR_SLA_NACK)) begin
                                error_next     = 1'b1;
                                res.bus_action = ACT_STOP;
                                done           = 1'b1;
                            end
                        end
                        CODE_MR_DATA_ACK, CODE_MR_DATA_NACK: begin
                            if (is_rd) begin
                                if (byte_position_reg < block_length_reg) begin
                                    res.rx_valid = 1'b1;
                                    res.rx_index = byte_position_reg;
                                    res.rx_byte  = in_reg.received_byte;
                                end
                                if (in_reg.bus_status == CODE_MR_DATA_ACK) begin
                                    byte_position_next = pos_adv;
                                    res.bus_action = ({1'b0, pos_adv} + 9'd1 < {1'b0, block_length_reg})
                                                     ? ACT_ACK : ACT_REL;
                                end else begin
                                    res.bus_action = ACT_STOP;
                                    done           = 1'b1;
                                end
                            end
                        end
                        CODE_MT_SLA_ACK: begin
                            if (!is_rd) begin
                                if (block_length_reg != 8'd0) begin
                                    res.tx_valid       = 1'b1;
                                    res.tx_byte        = rd_zero_data;
                                    byte_position_next = 8'd1;
                                    res.bus_action     = ACT_REL;
                                end else begin
                                    byte_position_next = '0;
                                    res.bus_action     = ACT_STOP;
                                    done               = 1'b1;
                                end
                            end
                        end
                        CODE_MT_DATA_ACK: begin
                            if (!is_rd) begin
                                if (byte_position_reg < block_length_reg) begin
                                    res.tx_valid = 1'b1;
                                    // positions past the store send zero
                                    res.tx_byte  = (int'(byte_position_reg) < STORE_DEPTH)
                                                   ? rd_pos_data : 8'd0;
                                    byte_position_next = pos_adv;
                                    res.bus_action     = ACT_REL;
                                end else begin
                                    res.bus_action = ACT_STOP;
                                    done           = 1'b1;
                                end
                            end
                        end
                        CODE_MT_DATA_NACK: begin
                            if (!is_rd) begin
                                if (byte_position_reg < block_length_reg) begin
                                    error_next = 1'b1;
                                end
                                res.bus_action = ACT_STOP;
                                done           = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        if (done) begin
            busy_next = 1'b0;
        end
        res.busy_res = busy_next;
        res.error    = error_next;
        res.done_res = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            address_byte_reg  <= '0;
            block_length_reg  <= '0;
            byte_position_reg <= '0;
            busy_reg          <= 1'b0;
            error_reg         <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg     <= 1'b1;
                address_byte_reg  <= address_byte_next;
                block_length_reg  <= block_length_next;
                byte_position_reg <= byte_position_next;
                busy_reg          <= busy_next;
                error_reg         <= error_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg <= res;
        end
    end

endmodule

// ----- rtl/i2cm_seq_chk.sv -----
// Port-level checker for the I2C master transfer sequencer, bound to the top level.
`include "assert_macros.svh"

module i2cm_seq_chk (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input i2cm_seq_pkg::i2cm_seq_out_t m_data
);
    import i2cm_seq_pkg::*;

    `I2CM_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "result word valid after reset")
    `I2CM_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled word changed")
    `I2CM_ASSERT(a_done_not_busy, m_valid && m_data.done_res |-> !m_data.busy_res, "done word still busy")
    `I2CM_ASSERT(a_tx_zero, m_valid && !m_data.tx_valid |-> m_data.tx_byte == 8'd0, "tx byte without tx_valid")
    // input side only backs up behind a stalled result word
    `I2CM_ASSERT(a_ready_stall, !s_ready |-> m_valid && !m_ready, "s_ready low without a stall")

endmodule

bind i2c_master_transfer_sequencer i2cm_seq_chk u_i2cm_seq_chk (.*);
